// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

  localparam int W = 32;
  localparam int DW = 31;
  localparam int CW = 6;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EXACT = 3'd4;
  localparam logic [2:0] OP_CAT = 3'd5;

  localparam logic signed [W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [W-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic [W-1:0] LIM_DIV10 = 32'd214748364;
  localparam logic [W-1:0] TEN = 32'd10;

  typedef struct packed {
    logic [2:0] opcode;
    logic signed [W-1:0] a_num;
    logic [DW-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic [DW-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic ok;
    logic signed [W-1:0] r_num;
    logic [DW-1:0] r_den;
  } out_t;

  // request to a bit-serial unit
  typedef struct packed {
    logic start;
    logic [W:0] x;
    logic [W:0] y;
  } sreq_t;

  typedef struct packed {
    logic done;
    logic [2*W+1:0] p;
  } mres_t;

  typedef struct packed {
    logic done;
    logic [W:0] q;
    logic [W:0] r;
  } dres_t;

endpackage

// ===== hw/rtl/rau_if.sv =====
interface rau_in_if (input logic clk);
  logic valid;
  logic ready;
  rau_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_out_if (input logic clk);
  logic valid;
  logic ready;
  rau_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rau_mul.sv =====
// unsigned shift-add multiplier, one multiplier bit per cycle
module rau_mul (
  input  logic clk,
  input  logic rst,
  input  rau_pkg::sreq_t req,
  output rau_pkg::mres_t res
);
  logic [rau_pkg::W:0] mcand;
  logic [2*rau_pkg::W+1:0] acc;
  logic [rau_pkg::CW-1:0] cnt;
  logic busy;
  logic done;
  logic [rau_pkg::W+1:0] sum;

  assign sum = acc[2*rau_pkg::W+1:rau_pkg::W+1] + (acc[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mcand <= req.x;
        acc <= {{(rau_pkg::W+1){1'b0}}, req.y};
        cnt <= '0;
      end else if (busy) begin
        acc <= {sum, acc[rau_pkg::W:1]};
        cnt <= cnt + 1'b1;
        if (cnt == rau_pkg::CW'(rau_pkg::W)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign res.done = done;
  assign res.p = acc;
endmodule

// ===== hw/rtl/rau_div.sv =====
// restoring divider, one quotient bit per cycle
module rau_div (
  input  logic clk,
  input  logic rst,
  input  rau_pkg::sreq_t req,
  output rau_pkg::dres_t res
);
  logic [rau_pkg::W:0] dvs;
  logic [rau_pkg::W:0] q;
  logic [rau_pkg::W:0] r;
  logic [rau_pkg::CW-1:0] cnt;
  logic busy;
  logic done;
  logic [rau_pkg::W+1:0] trial;

  assign trial = {r, q[rau_pkg::W]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q <= req.x;
        dvs <= req.y;
        r <= '0;
        cnt <= '0;
      end else if (busy) begin
        if (!trial[rau_pkg::W+1]) begin
          r <= trial[rau_pkg::W:0];
          q <= {q[rau_pkg::W-1:0], 1'b1};
        end else begin
          r <= {r[rau_pkg::W-1:0], q[rau_pkg::W]};
          q <= {q[rau_pkg::W-1:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == rau_pkg::CW'(rau_pkg::W)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign res.done = done;
  assign res.q = q;
  assign res.r = r;
endmodule

// ===== hw/rtl/rational_arith_unit_top.sv =====
// channel | dir | payload
// in      | in  | opcode, a_num, a_den, b_num, b_den
// out     | out | ok, r_num, r_den
//
// one word at a time; each pass through the bit-serial multiplier or the
// restoring divider runs issue, load, 33 bit steps and done.
// add/sub takes three products, mul and div two, concat one after a
// power-of-ten search; each gcd step is one divide pass and the
// reduction two more.
// rst is synchronous; in.ready is high only while no word is in flight;
// the result register holds until out.ready takes it and stalls the next finish.
module rational_arith_unit_top (
  input logic clk,
  input logic rst,
  rau_in_if.sink in,
  rau_out_if.source out
);
  localparam int W = rau_pkg::W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1 = 4'd1;  // first product
  localparam logic [3:0] S_M2 = 4'd2;  // second product
  localparam logic [3:0] S_MD = 4'd3;  // denominator product
  localparam logic [3:0] S_CHK = 4'd4;
  localparam logic [3:0] S_GCD = 4'd5;
  localparam logic [3:0] S_QN = 4'd6;
  localparam logic [3:0] S_QD = 4'd7;
  localparam logic [3:0] S_FIN = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_CAT = 4'd10;  // power-of-ten search

  logic [3:0] state;
  rau_pkg::in_t op;
  logic signed [W+1:0] x, y, dd;  // wide enough to detect overflow
  logic signed [W+1:0] n;
  logic [W:0] gx, gy, g, mn, md;
  logic [W:0] qn;
  logic [W-1:0] pw;
  logic fail, wait_u;

  rau_pkg::sreq_t mreq, dreq;
  rau_pkg::mres_t mres;
  rau_pkg::dres_t dres;

  rau_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .res(mres));
  rau_div u_div (.clk(clk), .rst(rst), .req(dreq), .res(dres));

  // signed product from magnitudes
  function automatic logic signed [W+1:0] sprod(input logic [2*W+1:0] p, input logic neg);
    logic [2*W+1:0] v;
    v = neg ? -p : p;
    // saturate to a marker outside 32-bit range when too large
    if (p > {{(W+1){1'b0}}, 1'b1, {W{1'b0}}})
      return neg ? -(34'sd1 <<< 32) : (34'sd1 <<< 32);
    return v[W+1:0];
  endfunction

  function automatic logic [W:0] mag(input logic signed [W+1:0] v);
    logic signed [W+1:0] a;
    a = v < 0 ? -v : v;
    return a[W:0];
  endfunction

  function automatic logic fits(input logic signed [W+1:0] v);
    return v >= 34'(rau_pkg::INT_MIN) && v <= 34'(rau_pkg::INT_MAX);
  endfunction

  logic sgn_x, sgn_y;
  logic signed [W+1:0] psel;
  assign psel = sprod(mres.p, sgn_x ^ sgn_y);

  assign in.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      mreq.start <= 1'b0;
      dreq.start <= 1'b0;
      wait_u <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      dreq.start <= 1'b0;
      // S_FIN reloads the result register itself
      if (out.valid && out.ready && state != S_FIN) out.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            op <= in.data;
            fail <= 1'b0;
            wait_u <= 1'b0;
            if (in.data.opcode == rau_pkg::OP_CAT) begin
              pw <= rau_pkg::TEN;
              state <= S_CAT;
            end else if (in.data.opcode > rau_pkg::OP_CAT) begin
              fail <= 1'b1;
              state <= S_FIN;
            end else
              state <= S_M1;
          end
        end
        S_CAT: begin
          if (op.a_den != 31'd1 || op.b_den != 31'd1 || op.a_num == 0 ||
              pw > rau_pkg::LIM_DIV10) begin
            fail <= 1'b1;
            state <= S_FIN;
          end else if ($signed({1'b0, pw}) <= 33'(op.b_num)) begin
            pw <= pw * rau_pkg::TEN;
          end else begin
            x <= 34'(op.b_num);
            dd <= 34'sd1;
            state <= S_M1;
          end
        end
        S_M1, S_M2, S_MD: begin
          if (!wait_u) begin
            wait_u <= 1'b1;
            mreq.start <= 1'b1;
            // operand selection per stage
            unique case (state)
              S_M1: begin
                if (op.opcode == rau_pkg::OP_CAT) begin
                  mreq.x <= mag(34'(op.a_num)); mreq.y <= {1'b0, pw};
                  sgn_x <= op.a_num[W-1]; sgn_y <= 1'b0;
                end else if (op.opcode == rau_pkg::OP_MUL) begin
                  mreq.x <= mag(34'(op.a_num)); mreq.y <= mag(34'(op.b_num));
                  sgn_x <= op.a_num[W-1]; sgn_y <= op.b_num[W-1];
                end else begin
                  mreq.x <= mag(34'(op.a_num)); mreq.y <= {2'b0, op.b_den};
                  sgn_x <= op.a_num[W-1]; sgn_y <= 1'b0;
                end
              end
              S_M2: begin
                mreq.x <= mag(34'(op.b_num)); mreq.y <= {2'b0, op.a_den};
                sgn_x <= op.b_num[W-1]; sgn_y <= 1'b0;
              end
              default: begin
                if (op.opcode == rau_pkg::OP_DIV || op.opcode == rau_pkg::OP_EXACT) begin
                  mreq.x <= {2'b0, op.a_den}; mreq.y <= mag(34'(op.b_num));
                  sgn_x <= 1'b0; sgn_y <= op.b_num[W-1];
                end else begin
                  mreq.x <= {2'b0, op.a_den}; mreq.y <= {2'b0, op.b_den};
                  sgn_x <= 1'b0; sgn_y <= 1'b0;
                end
              end
            endcase
          end else if (mres.done) begin
            wait_u <= 1'b0;
            unique case (state)
              S_M1: begin
                if (op.opcode == rau_pkg::OP_CAT) begin
                  if (!fits(psel)) fail <= 1'b1;
                  n <= psel + x;
                  state <= S_CHK;
                end else if (op.opcode == rau_pkg::OP_MUL) begin
                  n <= psel; state <= S_MD;
                end else begin
                  x <= psel;
                  state <= (op.opcode <= rau_pkg::OP_SUB) ? S_M2 : S_MD;
                end
              end
              S_M2: begin y <= psel; state <= S_MD; end
              default: begin dd <= psel; state <= S_CHK; end
            endcase
          end
        end
        S_CHK: begin
          // form numerator and check every term
          logic signed [W+1:0] nn;
          logic bad;
          bad = fail;
          nn = n;
          unique case (op.opcode)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
              if (!fits(x) || !fits(y)) bad = 1'b1;
              if (op.opcode == rau_pkg::OP_SUB && y == 34'(rau_pkg::INT_MIN)) bad = 1'b1;
              nn = (op.opcode == rau_pkg::OP_SUB) ? x - y : x + y;
            end
            rau_pkg::OP_DIV, rau_pkg::OP_EXACT: begin
              if (op.b_num == 0) bad = 1'b1;
              nn = x;
            end
            default: nn = n;
          endcase
          if (!fits(nn) || !fits(dd) || dd == 0) bad = 1'b1;
          n <= nn;
          mn <= mag(nn);
          md <= mag(dd);
          gx <= mag(nn);
          gy <= mag(dd);
          fail <= bad;
          state <= bad ? S_FIN : S_GCD;
        end
        S_GCD: begin
          if (!wait_u) begin
            if (gx == 0 || gy == 0) begin
              g <= gx | gy;
              dreq.start <= 1'b1;
              dreq.x <= mn;
              dreq.y <= gx | gy;
              wait_u <= 1'b1;
              state <= S_QN;
            end else begin
              dreq.start <= 1'b1;
              dreq.x <= gx;
              dreq.y <= gy;
              wait_u <= 1'b1;
            end
          end else if (dres.done) begin
            wait_u <= 1'b0;
            gx <= gy;
            gy <= dres.r;
          end
        end
        S_QN: begin
          if (dres.done) begin
            qn <= dres.q;
            dreq.start <= 1'b1;
            dreq.x <= md;
            dreq.y <= g;
            state <= S_QD;
          end
        end
        S_QD: begin
          if (dres.done) begin
            logic neg;
            logic signed [W+1:0] v;
            wait_u <= 1'b0;
            neg = n[W+1] ^ dd[W+1];
            v = neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
            if (!fits(v) || dres.q[W:W-1] != 2'b00) fail <= 1'b1;
            if ((op.opcode == rau_pkg::OP_EXACT) && dres.q != 33'd1) fail <= 1'b1;
            x <= v;
            md <= dres.q;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out.valid || out.ready) begin
            out.valid <= 1'b1;
            out.data.ok <= !fail;
            out.data.r_num <= fail ? '0 : x[W-1:0];
            out.data.r_den <= fail ? '0 : md[W-2:0];
            state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !wait_u) else $error("unit busy while idle");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.data.ok) |-> (out.data.r_den == 0)) else $error("failed word not zero");
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.data.ok) |-> (out.data.r_den != 0)) else $error("zero denominator");
endmodule
